FILE: rtl/wmt_pkg.sv
package wmt_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_TIME = 2'd2;
  localparam logic [1:0] ST_FIRED    = 2'd3;

  localparam logic       REG_WINDOW   = 1'b0;
  localparam logic [7:0] TODAY_ONLY   = 8'h80;
  localparam logic [16:0] DAY_SECONDS = 17'd86400;
  localparam logic [7:0] WINDOW_RESET = 8'd50;
  localparam logic [4:0] MAX_FIRES    = 5'd16;
  localparam logic [31:0] ID_LAST     = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_FIRST    = 32'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  day_mask;
    logic [16:0] time_of_day;
    logic        one_shot;
    logic [31:0] target_id;
    logic [2:0]  weekday_now;
    logic [31:0] uptime_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_id;
    logic        last;
  } out_item_t;

  // fixed part of a table entry; the armed time lives in its own memory
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  day_mask;
    logic [16:0] tod;
    logic        one_shot;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DEL_RD,
    S_DEL_CHK,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_END
  } state_t;

endpackage

FILE: rtl/wmt_store.sv
module wmt_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  ent_we,
  input  logic [IDX_W-1:0]      ent_waddr,
  input  wmt_pkg::entry_t       ent_wdata,
  input  logic                  at_we,
  input  logic [IDX_W-1:0]      at_waddr,
  input  logic [31:0]           at_wdata,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output wmt_pkg::entry_t       rd_ent,
  output logic [31:0]           rd_at
);
  import wmt_pkg::*;

  entry_t      ent_mem [DEPTH];
  logic [31:0] at_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (rd_en) begin
      rd_ent <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (at_we) begin
      at_mem[at_waddr] <= at_wdata;
    end
    if (rd_en) begin
      rd_at <= at_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/wmt_cfg.sv
module wmt_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  window
);
  import wmt_pkg::*;

  logic [7:0] window_r;
  logic [7:0] window_nxt;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
  assign window_nxt = wr_hit ? pwdata[7:0] : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW) ? {24'd0, window_r} : 32'd0;
  assign window = window_r;

endmodule

FILE: rtl/weekly_alarm_table_top.sv
// Weekly alarm table. Each input word is an add, a delete or a one-second tick.
// An add answers with one word (added, table full or time out of range), which
// waits on out_ready. A delete answers nothing and searches the table newest
// first. A tick walks the table newest first at one entry a cycle (one memory
// read port) while out_ready does not stall it; it emits one fired word per
// alarm that goes off, at most sixteen, and flags the final one with last.
// Entry fields live in two simple dual-port memories (one write port, one
// registered read port each); age order is kept as a list of slot pointers in
// flops.
// advance_window is register 0 at byte address 0 and may be written only
// while the block is idle.
module weekly_alarm_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wmt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wmt_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wmt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  in_item_t   item_r, item_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] wpos_r, wpos_nxt;
  logic [4:0]  fires_r, fires_nxt;
  logic [31:0] id_ctr_r, id_ctr_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [31:0] pend_id_r, pend_id_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_r, out_nxt;

  logic [IDX_W-1:0] ord_r    [TABLE_DEPTH];
  logic [IDX_W-1:0] ord_nxt  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] pvalid_r, pvalid_nxt;
  logic [TABLE_DEPTH-1:0] armed_r, armed_nxt;

  logic [7:0]  window;

  // memory side
  logic             ent_we, at_we, rd_en;
  logic [IDX_W-1:0] ent_waddr, at_waddr, rd_addr;
  entry_t           ent_wdata, rd_ent;
  logic [31:0]      at_wdata, rd_at;

  // scan datapath
  logic [IDX_W-1:0] pos_idx, pos_idx_next, phys, free_idx;
  logic [CNT_W-1:0] pos_inc;
  logic             out_free;
  logic             hit, armed_cur, do_arm, armed_eff, fire, keep, in_win;
  logic [17:0]      diff;
  logic [31:0]      armed_at_eff;

  wmt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  wmt_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk       (clk),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .at_we     (at_we),
    .at_waddr  (at_waddr),
    .at_wdata  (at_wdata),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_ent    (rd_ent),
    .rd_at     (rd_at)
  );

  assign out_free     = !out_vld_r || out_ready;
  assign pos_idx      = pos_r[IDX_W-1:0];
  assign pos_inc      = pos_r + CNT_W'(1);
  assign pos_idx_next = pos_inc[IDX_W-1:0];
  assign phys         = ord_r[pos_idx];

  // lowest free physical slot
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!pvalid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // per-entry tick evaluation on the word just read back
  always_comb begin
    hit          = rd_ent.day_mask[item_r.weekday_now] || (rd_ent.day_mask == TODAY_ONLY);
    armed_cur    = armed_r[phys];
    diff         = {1'b0, rd_ent.tod} - {1'b0, item_r.time_of_day};
    in_win       = !diff[17] && (diff[16:8] == 9'd0) && (diff[7:0] <= window);
    do_arm       = hit && !armed_cur && in_win;
    armed_eff    = armed_cur || do_arm;
    armed_at_eff = do_arm ? (item_r.uptime_seconds + 32'(diff[16:0])) : rd_at;
    fire         = hit && armed_eff && (item_r.uptime_seconds >= armed_at_eff) &&
                   (fires_r < MAX_FIRES);
    keep         = !(fire && (rd_ent.one_shot || (rd_ent.day_mask == TODAY_ONLY)));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            KIND_ADD:    state_nxt = S_ADD;
            KIND_DELETE: state_nxt = (n_r == '0) ? S_IDLE : S_DEL_RD;
            KIND_TICK:   state_nxt = (n_r == '0) ? S_TICK_END : S_TICK_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEL_RD: state_nxt = S_DEL_CHK;
      S_DEL_CHK: begin
        if (rd_ent.id == item_r.target_id || pos_inc == n_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK_RD: state_nxt = S_TICK_CHK;
      S_TICK_CHK: begin
        if (!(fire && pend_vld_r && !out_free) && pos_inc == n_r) begin
          state_nxt = S_TICK_END;
        end
      end
      S_TICK_END: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    item_nxt     = item_r;
    n_nxt        = n_r;
    pos_nxt      = pos_r;
    wpos_nxt     = wpos_r;
    fires_nxt    = fires_r;
    id_ctr_nxt   = id_ctr_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    ord_nxt      = ord_r;
    pvalid_nxt   = pvalid_r;
    armed_nxt    = armed_r;
    in_ready     = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = free_idx;
    ent_wdata    = '{id: id_ctr_r, day_mask: item_r.day_mask,
                     tod: item_r.time_of_day, one_shot: item_r.one_shot};
    at_we        = 1'b0;
    at_waddr     = phys;
    at_wdata     = armed_at_eff;
    rd_en        = 1'b0;
    rd_addr      = phys;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt     = in_data;
          pos_nxt      = '0;
          wpos_nxt     = '0;
          fires_nxt    = '0;
          pend_vld_nxt = 1'b0;
        end
      end

      S_ADD: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_nxt     = '{status: ST_ADDED, entry_id: id_ctr_r, last: 1'b1};
          if (item_r.time_of_day >= DAY_SECONDS) begin
            out_nxt.status   = ST_BAD_TIME;
            out_nxt.entry_id = '0;
          end else if (n_r == CNT_W'(TABLE_DEPTH)) begin
            out_nxt.status   = ST_FULL;
            out_nxt.entry_id = '0;
          end else begin
            // push the new slot in front of the age list
            ent_we               = 1'b1;
            pvalid_nxt[free_idx] = 1'b1;
            armed_nxt[free_idx]  = 1'b0;
            for (int j = 1; j < TABLE_DEPTH; j++) begin
              ord_nxt[j] = ord_r[j-1];
            end
            ord_nxt[0] = free_idx;
            n_nxt      = n_r + CNT_W'(1);
            id_ctr_nxt = (id_ctr_r == ID_LAST) ? ID_FIRST : id_ctr_r + 32'd1;
          end
        end
      end

      S_DEL_RD: begin
        rd_en = 1'b1;
      end

      S_DEL_CHK: begin
        if (rd_ent.id == item_r.target_id) begin
          // close the gap, newer entries keep their places
          for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
            if (CNT_W'(j) >= pos_r) begin
              ord_nxt[j] = ord_r[j+1];
            end
          end
          pvalid_nxt[phys] = 1'b0;
          armed_nxt[phys]  = 1'b0;
          n_nxt            = n_r - CNT_W'(1);
        end else if (pos_inc != n_r) begin
          rd_en   = 1'b1;
          rd_addr = ord_r[pos_idx_next];
          pos_nxt = pos_inc;
        end
      end

      S_TICK_RD: begin
        rd_en = 1'b1;
      end

      S_TICK_CHK: begin
        if (!(fire && pend_vld_r && !out_free)) begin
          at_we           = do_arm;
          armed_nxt[phys] = armed_eff && !fire;
          if (keep) begin
            ord_nxt[wpos_r[IDX_W-1:0]] = phys;
            wpos_nxt = wpos_r + CNT_W'(1);
          end else begin
            pvalid_nxt[phys] = 1'b0;
          end
          if (fire) begin
            // hold the newest fire back until we know whether it is the final one
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = '{status: ST_FIRED, entry_id: pend_id_r, last: 1'b0};
            end
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = rd_ent.id;
            fires_nxt    = fires_r + 5'd1;
          end
          if (pos_inc != n_r) begin
            rd_en   = 1'b1;
            rd_addr = ord_r[pos_idx_next];
            pos_nxt = pos_inc;
          end
        end
      end

      S_TICK_END: begin
        n_nxt = wpos_r;
        if (pend_vld_r && out_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = '{status: ST_FIRED, entry_id: pend_id_r, last: 1'b1};
          pend_vld_nxt = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      n_r        <= '0;
      pvalid_r   <= '0;
      armed_r    <= '0;
      id_ctr_r   <= ID_FIRST;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      pos_r      <= '0;
      wpos_r     <= '0;
      fires_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      pvalid_r   <= pvalid_nxt;
      armed_r    <= armed_nxt;
      id_ctr_r   <= id_ctr_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      pos_r      <= pos_nxt;
      wpos_r     <= wpos_nxt;
      fires_r    <= fires_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    pend_id_r <= pend_id_nxt;
    out_r     <= out_nxt;
    ord_r     <= ord_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_slots_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(pvalid_r) == int'(n_r)))
    else $error("occupied slots disagree with entry count");

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fires_r <= MAX_FIRES)
    else $error("too many fires in one tick");

  a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_vld_r)
    else $error("fire left pending after tick");

endmodule
